### sv/overwriting_byte_ring_buffer_defines.svh
// Assertion macros for the overwriting byte ring buffer.
`ifndef OVERWRITING_BYTE_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_BYTE_RING_BUFFER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define OBRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("obrb: implication check failed");

// Next-cycle implication, disabled in reset.
`define OBRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("obrb: next-cycle check failed");

`else

`define OBRB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define OBRB_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

### sv/obrb_pkg.sv
// Shared types and constants for the overwriting byte ring buffer.
package obrb_pkg;

  localparam int DEFAULT_DEPTH = 256;
  localparam int MAX_SLOTS     = 256;
  localparam int DATA_W        = 8;
  localparam int KIND_W        = 2;
  localparam int CFG_W         = 9;
  localparam int COUNT_W       = 8;
  localparam int MIN_SLOTS     = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture operation on the input transfer
    logic exec;  // carry out the captured operation this cycle
  } obrb_cmd_t;

endpackage

### sv/obrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module obrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/obrb_ctrl.sv
// Control state machine: accepts an operation and sequences its execution.
module obrb_ctrl import obrb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output obrb_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    busy_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // head slot read data is valid now
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/obrb_dp.sv
// Datapath: byte store, head/tail pointers, size register and result registers.
module obrb_dp import obrb_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  obrb_cmd_t          cmd_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [DATA_W-1:0]  data_in_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               result_valid_o,
  output logic [DATA_W-1:0]  data_out_o,
  output logic               was_empty_o,
  output logic               dropped_o,
  output logic [COUNT_W-1:0] count_o,
  output logic               now_empty_o,
  output logic               now_full_o
);

  localparam int SLOTS = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int SZ_W  = $clog2(SLOTS + 1);

  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [SZ_W-1:0]    size_q, size_d;
  op_kind_e           kind_q;
  logic [DATA_W-1:0]  data_q;
  logic [DATA_W-1:0]  rd_data;
  logic               mem_we;
  logic               valid_q;
  logic [DATA_W-1:0]  data_out_q, data_out_d;
  logic               was_empty_q, was_empty_d;
  logic               dropped_q, dropped_d;
  logic [SZ_W-1:0]    cnt;
  logic [COUNT_W-1:0] count_q;
  logic               now_empty_q, now_full_q;
  logic               is_empty;
  logic [IDX_W-1:0]   tail_adv, head_adv;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [SZ_W-1:0]  size);
    logic [SZ_W-1:0] n;
    n = SZ_W'(idx) + SZ_W'(1);
    return (n >= size) ? '0 : IDX_W'(n);
  endfunction

  obrb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (data_q),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  // clamp the written size into [2, SLOTS]
  always_comb begin
    if (cfg_wdata_i < CFG_W'(MIN_SLOTS)) begin
      size_d = SZ_W'(MIN_SLOTS);
    end else if (cfg_wdata_i > CFG_W'(SLOTS)) begin
      size_d = SZ_W'(SLOTS);
    end else begin
      size_d = SZ_W'(cfg_wdata_i);
    end
  end

  assign is_empty = (head_q == tail_q);
  assign tail_adv = advance(tail_q, size_q);
  assign head_adv = advance(head_q, size_q);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    mem_we      = 1'b0;
    data_out_d  = '0;
    was_empty_d = 1'b0;
    dropped_d   = 1'b0;
    case (kind_q)
      OP_PUSH: begin
        // full: drop the oldest byte before storing
        if (tail_adv == head_q) begin
          head_d    = head_adv;
          dropped_d = 1'b1;
        end
        mem_we = cmd_i.exec;
        tail_d = tail_adv;
      end
      OP_POP, OP_PEEK: begin
        if (is_empty) begin
          was_empty_d = 1'b1;
        end else begin
          data_out_d = rd_data;
          if (kind_q == OP_POP) begin
            head_d = head_adv;
          end
        end
      end
      OP_FLUSH: begin
        head_d = '0;
        tail_d = '0;
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_comb begin
    if (tail_d >= head_d) begin
      cnt = SZ_W'(tail_d) - SZ_W'(head_d);
    end else begin
      cnt = size_q - SZ_W'(head_d) + SZ_W'(tail_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      size_q  <= SZ_W'(SLOTS);
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cfg_we_i) begin
        size_q <= size_d;
        head_q <= '0;
        tail_q <= '0;
      end else if (cmd_i.exec) begin
        head_q <= head_d;
        tail_q <= tail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= op_kind_e'(kind_i);
      data_q <= data_in_i;
    end
    if (cmd_i.exec) begin
      data_out_q  <= data_out_d;
      was_empty_q <= was_empty_d;
      dropped_q   <= dropped_d;
      count_q     <= COUNT_W'(cnt);
      now_empty_q <= (cnt == '0);
      now_full_q  <= (cnt == size_q - SZ_W'(1));
    end
  end

  assign result_valid_o = valid_q;
  assign data_out_o     = data_out_q;
  assign was_empty_o    = was_empty_q;
  assign dropped_o      = dropped_q;
  assign count_o        = count_q;
  assign now_empty_o    = now_empty_q;
  assign now_full_o     = now_full_q;

endmodule

### sv/overwriting_byte_ring_buffer.sv
// Top level of the overwriting byte ring buffer.
//
//  channel   handshake                    payload
//  -------   --------------------------   --------------------------------------------
//  command   start (in), busy (out)       kind_i, data_in_i
//  result    result_valid_o, one cycle    data_out_o, was_empty_o, dropped_o, count_o,
//                                         now_empty_o, now_full_o
//  config    cfg_we_i                     cfg_wdata_i (queue size, clamped to 2..slots)
//
// In each operation the transfer cycle issues the head-slot read, and the next (busy)
// cycle uses the registered read data and updates the pointers. The result strobe
// follows in the cycle after the busy one; the next command can already be taken.
// Reset empties the buffer and sets the size to the full slot count; the store itself
// is not cleared. A size write also empties the buffer. Results cannot be stalled.
`include "overwriting_byte_ring_buffer_defines.svh"

module overwriting_byte_ring_buffer import obrb_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [DATA_W-1:0]  data_in_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               result_valid_o,
  output logic [DATA_W-1:0]  data_out_o,
  output logic               was_empty_o,
  output logic               dropped_o,
  output logic [COUNT_W-1:0] count_o,
  output logic               now_empty_o,
  output logic               now_full_o
);

  obrb_cmd_t cmd;

  obrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  obrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .data_in_i      (data_in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .data_out_o     (data_out_o),
    .was_empty_o    (was_empty_o),
    .dropped_o      (dropped_o),
    .count_o        (count_o),
    .now_empty_o    (now_empty_o),
    .now_full_o     (now_full_o)
  );

  // a transfer always leads into exactly one busy cycle, then one result
  `OBRB_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `OBRB_ASSERT_NXT(a_busy_result, clk_i, rst_ni, busy, result_valid_o && !busy)
  // capacity is at least one byte, so empty and full never coincide
  `OBRB_ASSERT_IMP(a_empty_full, clk_i, rst_ni, result_valid_o,
                   !(now_empty_o && now_full_o))
  `OBRB_ASSERT_IMP(a_drop_full, clk_i, rst_ni, result_valid_o && dropped_o, now_full_o)

endmodule
